### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_ON_RUN(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

### rtl/fir_fc_pkg.sv
package fir_fc_pkg;

    localparam int TAPS = 8;
    localparam int HALF_TAPS = TAPS / 2;
    localparam int TAIL_W = $clog2(TAPS);

    localparam int SAMPLE_W = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int PSUM_W = PROD_W + 2;
    localparam int OUT_W = 35;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_HI = 2'd2;

    localparam logic [3:0] TAP_COUNT_RESET = 4'd8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PSUM_W-1:0] t_psum;

    // Coefficient k from the two packed registers; taps 0..3 in lo, 4..7 in hi.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [2:0] k
    );
        logic [CFG_DATA_W-1:0] word;
        word = k[2] ? hi : lo;
        return word[{k[1:0], 4'b0000} +: COEF_W];
    endfunction

endpackage

### rtl/fir_full_convolution.sv
// Channel     | Direction | Handshake               | Payload
// input item  | in        | i_valid / o_stall       | i_sample, i_end_of_signal
// result item | out       | o_valid / i_stall       | o_filtered, o_last_output
// config      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One sample can be taken every cycle while o_stall is low; its result is then offered
// from the output stage. A sample marked end_of_signal is followed by one tail result
// per cycle unless stalled, active tap count less one in all, with o_stall held high.
// Four register stages (window, products, partial sums, output) each advance when
// the stage after them is empty or moving, so an output stall backs up stage by stage.
// Reset is synchronous, clears the delay line and stage valids and resets the configuration.
module fir_full_convolution (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [15:0]                 i_sample,
    input  logic                               i_end_of_signal,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [34:0]                 o_filtered,
    output logic                               o_last_output,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fir_fc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fir_fc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration
    logic [3:0]                          r_tap_count;
    logic [fir_fc_pkg::CFG_DATA_W-1:0]   r_coef_lo;
    logic [fir_fc_pkg::CFG_DATA_W-1:0]   r_coef_hi;
    logic [3:0]                          w_nt;

    // Front end
    fir_fc_pkg::t_sample                 r_dly [fir_fc_pkg::TAPS-1];
    logic [fir_fc_pkg::TAIL_W-1:0]       r_tail_cnt;
    logic                                w_take_in;
    logic                                w_take_tail;
    logic                                w_clear;
    fir_fc_pkg::t_sample                 w_head;

    // Pipeline
    logic                                w_en1, w_en2, w_en3, w_en4;
    logic                                r_v1, r_v2, r_v3, r_v4;
    logic                                r_last1, r_last2, r_last3, r_last4;
    fir_fc_pkg::t_sample                 r_win [fir_fc_pkg::TAPS];
    fir_fc_pkg::t_prod                   r_prod [fir_fc_pkg::TAPS];
    fir_fc_pkg::t_psum                   r_psum_a, r_psum_b;
    fir_fc_pkg::t_psum                   n_psum_a, n_psum_b;
    logic signed [fir_fc_pkg::OUT_W-1:0] r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fir_fc_pkg::TAP_COUNT_RESET;
            r_coef_lo   <= '0;
            r_coef_hi   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fir_fc_pkg::REG_TAP_COUNT: r_tap_count <= i_cfg_data[3:0];
                fir_fc_pkg::REG_COEF_LO:   r_coef_lo   <= i_cfg_data;
                fir_fc_pkg::REG_COEF_HI:   r_coef_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A count of zero behaves as one tap, anything above the tap total as all.
    always_comb begin
        if (r_tap_count == 4'd0) begin
            w_nt = 4'd1;
        end else if (r_tap_count > 4'(fir_fc_pkg::TAPS)) begin
            w_nt = 4'(fir_fc_pkg::TAPS);
        end else begin
            w_nt = r_tap_count;
        end
    end

    assign w_en4 = !r_v4 || !i_stall;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign w_take_in   = i_valid && (r_tail_cnt == '0) && w_en1;
    assign w_take_tail = (r_tail_cnt != '0) && w_en1;
    assign o_stall     = (r_tail_cnt != '0) || !w_en1;
    assign w_head      = w_take_in ? i_sample : '0;

    // The delay line is cleared once the final output of a signal is formed.
    assign w_clear = (w_take_in && i_end_of_signal && (w_nt == 4'd1))
                  || (w_take_tail && (r_tail_cnt == fir_fc_pkg::TAIL_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cnt <= '0;
            for (int k = 0; k < fir_fc_pkg::TAPS - 1; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            if (w_take_in && i_end_of_signal) begin
                r_tail_cnt <= fir_fc_pkg::TAIL_W'(w_nt - 4'd1);
            end else if (w_take_tail) begin
                r_tail_cnt <= r_tail_cnt - fir_fc_pkg::TAIL_W'(1);
            end
            if (w_take_in || w_take_tail) begin
                if (w_clear) begin
                    for (int k = 0; k < fir_fc_pkg::TAPS - 1; k++) begin
                        r_dly[k] <= '0;
                    end
                end else begin
                    r_dly[0] <= w_head;
                    for (int k = 1; k < fir_fc_pkg::TAPS - 1; k++) begin
                        r_dly[k] <= r_dly[k-1];
                    end
                end
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= w_take_in || w_take_tail;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // Window stage: taps beyond the active count are loaded as zero.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_win[0] <= w_head;
            for (int k = 1; k < fir_fc_pkg::TAPS; k++) begin
                r_win[k] <= (4'(k) < w_nt) ? r_dly[k-1] : '0;
            end
            r_last1 <= w_take_in ? (i_end_of_signal && (w_nt == 4'd1))
                                 : (r_tail_cnt == fir_fc_pkg::TAIL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            for (int k = 0; k < fir_fc_pkg::TAPS; k++) begin
                r_prod[k] <= fir_fc_pkg::coef_at(r_coef_lo, r_coef_hi, 3'(k)) * r_win[k];
            end
            r_last2 <= r_last1;
        end
    end

    always_comb begin
        n_psum_a = '0;
        n_psum_b = '0;
        for (int k = 0; k < fir_fc_pkg::TAPS; k++) begin
            if (k < fir_fc_pkg::HALF_TAPS) begin
                n_psum_a = n_psum_a + fir_fc_pkg::PSUM_W'(r_prod[k]);
            end else begin
                n_psum_b = n_psum_b + fir_fc_pkg::PSUM_W'(r_prod[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_psum_a <= n_psum_a;
            r_psum_b <= n_psum_b;
            r_last3  <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out   <= fir_fc_pkg::OUT_W'(r_psum_a) + fir_fc_pkg::OUT_W'(r_psum_b);
            r_last4 <= r_last3;
        end
    end

    assign o_valid       = r_v4;
    assign o_filtered    = r_out;
    assign o_last_output = r_last4;

endmodule

### rtl/fir_fc_checker.sv
`include "assert_macros.svh"

module fir_fc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [34:0]                 o_filtered,
    input  logic                               o_last_output
);

    // A result held back by the consumer stays offered.
    `ASSERT_ON_RUN(a_out_hold, o_valid && i_stall |=> o_valid)

    // A result held back by the consumer keeps its payload.
    `ASSERT_ON_RUN(a_out_stable, o_valid && i_stall |=> $stable({o_filtered, o_last_output}))

    // Reset empties the pipeline: nothing is offered after a reset cycle.
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

    // Right after reset the block is free to take an item.
    `ASSERT_ALWAYS(a_reset_ready, !i_rst_n ##1 i_rst_n |-> !o_stall)

endmodule

bind fir_full_convolution fir_fc_checker u_fir_fc_checker (.*);

### bench/fir_full_convolution_test.sv
`timescale 1ns / 1ps

module fir_full_convolution_test;

    localparam logic [fir_fc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD_CYCLES = 80;

    typedef struct packed {
        logic signed [fir_fc_pkg::OUT_W-1:0] filtered;
        logic                                last_output;
    } t_conv_out;

    // Tracks the filter's registers and delay line and holds the outputs
    // still owed by the block, oldest first.
    class t_conv_scoreboard;
        logic [3:0]                             tap_count_reg;
        logic [fir_fc_pkg::CFG_DATA_W-1:0]      coef_lo;
        logic [fir_fc_pkg::CFG_DATA_W-1:0]      coef_hi;
        logic signed [fir_fc_pkg::SAMPLE_W-1:0] history [fir_fc_pkg::TAPS-1];
        t_conv_out                              owed [$];
        int                                     errors;

        function new();
            tap_count_reg = fir_fc_pkg::TAP_COUNT_RESET;
            coef_lo = '0;
            coef_hi = '0;
            foreach (history[i]) history[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [fir_fc_pkg::CFG_IDX_W-1:0] idx,
                                logic [fir_fc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fir_fc_pkg::REG_TAP_COUNT: tap_count_reg = data[3:0];
                fir_fc_pkg::REG_COEF_LO: coef_lo = data;
                fir_fc_pkg::REG_COEF_HI: coef_hi = data;
                default: ;
            endcase
        endfunction

        function int taps_in_use();
            if (tap_count_reg == 0) return 1;
            if (tap_count_reg > fir_fc_pkg::TAPS) return fir_fc_pkg::TAPS;
            return int'(tap_count_reg);
        endfunction

        function logic signed [fir_fc_pkg::COEF_W-1:0] weight(int k);
            logic [fir_fc_pkg::CFG_DATA_W-1:0] word;
            word = (k < 4) ? coef_lo : coef_hi;
            return word[16 * (k % 4) +: fir_fc_pkg::COEF_W];
        endfunction

        // Multiply-accumulate over the active taps, then shift x into the line.
        function logic signed [fir_fc_pkg::OUT_W-1:0] shift_in(
            logic signed [fir_fc_pkg::SAMPLE_W-1:0] x, int nt);
            longint acc;
            acc = longint'(weight(0)) * longint'(x);
            for (int k = 1; k < nt; k++)
                acc += longint'(weight(k)) * longint'(history[k-1]);
            for (int k = fir_fc_pkg::TAPS - 2; k > 0; k--)
                history[k] = history[k-1];
            history[0] = x;
            return acc[fir_fc_pkg::OUT_W-1:0];
        endfunction

        function void note_sample(logic signed [fir_fc_pkg::SAMPLE_W-1:0] x, logic eos);
            int        nt;
            t_conv_out r;
            nt = taps_in_use();
            r.filtered = shift_in(x, nt);
            r.last_output = eos && (nt == 1);
            owed.push_back(r);
            if (eos) begin
                for (int t = 1; t < nt; t++) begin
                    r.filtered = shift_in('0, nt);
                    r.last_output = (t == nt - 1);
                    owed.push_back(r);
                end
                foreach (history[i]) history[i] = '0;
            end
        endfunction

        function void check_result(logic signed [fir_fc_pkg::OUT_W-1:0] f, logic last);
            t_conv_out e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected output, expected none, got filtered %0d last %0b",
                         $time, f, last);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (f !== e.filtered) begin
                $display("%0t: filtered mismatch, expected %0d, got %0d",
                         $time, e.filtered, f);
                errors++;
            end
            if (last !== e.last_output) begin
                $display("%0t: last_output mismatch, expected %0b, got %0b",
                         $time, e.last_output, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_valid = 1'b0;
    logic                                   o_stall;
    logic signed [fir_fc_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic                                   i_end_of_signal = 1'b0;
    logic                                   o_valid;
    logic                                   i_stall = 1'b0;
    logic signed [fir_fc_pkg::OUT_W-1:0]    o_filtered;
    logic                                   o_last_output;
    logic                                   i_cfg_valid = 1'b0;
    logic                                   o_cfg_ready;
    logic [fir_fc_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [fir_fc_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;

    t_conv_scoreboard sb = new();

    bit quiet = 1'b0;
    bit tx_bursty = 1'b0;
    bit long_hold_req = 1'b0;
    int rx_hold = 0;
    int rx_burst = 0;
    int rx_mode_left = 0;
    bit rx_bursty = 1'b0;
    int stuck_cycles = 0;
    int sent = 0;

    fir_full_convolution uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_end_of_signal(i_end_of_signal),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered     (o_filtered),
        .o_last_output  (o_last_output),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The register write is noted before the sample, and the sample before
    // its outputs are checked, all at the edge where each is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall)
                sb.note_sample(i_sample, i_end_of_signal);
            if (o_valid && !i_stall)
                sb.check_result(o_filtered, o_last_output);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Output side: alternates between calm and bursty stretches, and serves
    // one long hold on request.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_bursty = ($urandom_range(0, 1) == 1);
            rx_mode_left = $urandom_range(30, 120);
        end else begin
            rx_mode_left--;
        end
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_hold = LONG_HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_stall <= 1'b1;
        end else if (!quiet && rx_bursty && $urandom_range(0, 7) == 0) begin
            rx_burst = $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic signed [fir_fc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [fir_fc_pkg::CFG_DATA_W-1:0] pick_coefs();
        case ($urandom_range(0, 5))
            0: return {4{16'h8000}};
            1: return {4{16'h7FFF}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] pick_taps();
        case ($urandom_range(0, 5))
            0: return 4'd1;
            1: return 4'd8;
            2: return 4'd0;
            3: return 4'd15;
            default: return 4'($urandom_range(1, fir_fc_pkg::TAPS));
        endcase
    endfunction

    task automatic put_reg(logic [fir_fc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fir_fc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic program_filter(logic [3:0] taps, logic [fir_fc_pkg::CFG_DATA_W-1:0] lo,
                                  logic [fir_fc_pkg::CFG_DATA_W-1:0] hi, bit stray);
        put_reg(fir_fc_pkg::REG_TAP_COUNT, {60'b0, taps});
        put_reg(fir_fc_pkg::REG_COEF_LO, lo);
        put_reg(fir_fc_pkg::REG_COEF_HI, hi);
        if (stray)
            put_reg(REG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic signed [fir_fc_pkg::SAMPLE_W-1:0] x, logic eos);
        if (!quiet && tx_bursty && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= x;
        i_end_of_signal <= eos;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_signal(int len, bit close);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(), close && (i == len - 1));
    endtask

    task automatic await_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Registers change only once the pipeline has drained.
    task automatic settle();
        await_results();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_stimulus();
        int phase;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: eight taps, all weights zero.
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sh8000, 1'b1);

        // Most negative weights times most negative samples: largest sum.
        settle();
        program_filter(4'd8, {4{16'h8000}}, {4{16'h8000}}, 1'b1);
        for (int i = 0; i < 8; i++) send_item(16'sh8000, i == 7);

        // Tap count above the maximum, then reduced in the middle of a signal.
        settle();
        program_filter(4'd15, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0);
        for (int i = 0; i < 3; i++) send_item(16'sh8000, 1'b0);
        settle();
        program_filter(4'd3, 64'h8000_7FFF_0001_FFFF, {4{16'h7FFF}}, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sd12345, 1'b1);

        // Zero taps behave as one: the marked sample is its own last output.
        settle();
        program_filter(4'd0, {4{16'h8000}}, 64'h0, 1'b0);
        send_item(16'sh7FFF, 1'b1);
        send_item(16'sh8000, 1'b1);
        settle();
        program_filter(4'd1, 64'h1234_5678_9ABC_7FFF, 64'hFFFF_0000_8000_7FFF, 1'b0);
        send_item(16'sd5, 1'b1);

        phase = 0;
        while (sent < 330) begin
            settle();
            program_filter(pick_taps(), pick_coefs(), pick_coefs(), $urandom_range(0, 3) == 0);
            quiet = (sent >= 280);
            tx_bursty = $urandom_range(0, 2) != 0;
            if (phase == 2) begin
                // Back-to-back items against a long output hold fill the pipeline.
                tx_bursty = 1'b0;
                long_hold_req = 1'b1;
                send_signal(24, 1'b1);
            end
            repeat ($urandom_range(2, 4))
                send_signal($urandom_range(1, 12), $urandom_range(0, 5) != 0);
            if (phase == 4) begin
                await_results();
                send_signal($urandom_range(4, 12), 1'b1);
            end
            phase++;
        end

        await_results();
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        fork
            run_stimulus();
            begin
                while (stuck_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
            end
        join_any
        if (stuck_cycles < WATCHDOG_LIMIT && sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
